@@ src/itrd_pkg.sv @@
package itrd_pkg;

  localparam int VALUE_W           = 32;
  localparam int RADIX_W           = 7;
  localparam int CHAR_W            = 7;
  localparam int DIGIT_W           = 5;
  localparam int BASE_W            = 6;
  localparam int CHUNK_BITS        = 8;
  localparam int CHUNKS            = VALUE_W / CHUNK_BITS;
  localparam int CHUNK_CNT_W       = $clog2(CHUNKS);
  localparam int MAX_CHARS_DEFAULT = 34;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd10;
  localparam logic [RADIX_W-1:0] BASE_MIN    = 7'd2;
  localparam logic [RADIX_W-1:0] BASE_MAX    = 7'd32;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO   = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A      = 7'h61;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS  = 7'h2d;
  localparam logic [CHAR_W-1:0]  DIGIT_TEN   = 7'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 5'd9;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_ZERO,
    ST_DIV,
    ST_FIN,
    ST_CHECK,
    ST_SIGN,
    ST_PREP,
    ST_READ,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic load;
    logic div;
    logic fin;
    logic put_zero;
    logic put_sign;
    logic prep;
    logic rd;
    logic next;
  } cmd_t;

  typedef struct packed {
    logic mag_zero;
    logic base_ok;
    logic full;
    logic sign_needed;
    logic idx_zero;
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] dval);
    logic [CHAR_W-1:0] ext;
    ext = {{(CHAR_W-DIGIT_W){1'b0}}, dval};
    if (dval <= DIGIT_NINE) begin
      digit_char = CHAR_ZERO + ext;
    end else begin
      digit_char = CHAR_A - DIGIT_TEN + ext;
    end
  endfunction

endpackage

@@ src/integer_to_radix_digits_core.sv @@
// Converts a signed 32-bit integer into its ASCII digit string in the base held
// in the radix register (2 to 32, or -32 to -2 for negabase), most significant
// character first, with tlast on the final character. One item is handled at
// a time. A shared divider works through the magnitude in chunks of eight
// restoring division steps to produce each digit, then stores the character
// and tests for completion. After the last digit, a minus sign is stored for a
// negative value in a positive base, readback is set up, and each character is
// then read from the single-port character buffer and offered on the output.
// A zero value or an unusable base gives the single character '0'.
module integer_to_radix_digits_core #(
  parameter int MAX_CHARS = itrd_pkg::MAX_CHARS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,  // radix, signed
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,    // value, signed
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // char_code [6:0], zero fill [7]
  output logic        m_tlast
);

  itrd_pkg::cmd_t                  cmd;
  itrd_pkg::status_t               status;
  logic [itrd_pkg::CHAR_W-1:0]     char_code;

  itrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  itrd_dp #(
    .MAX_CHARS (MAX_CHARS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .value     (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .char_code (char_code)
  );

  assign m_tdata = {1'b0, char_code};
  assign m_tlast = status.idx_zero;

endmodule

@@ src/itrd_ctrl.sv @@
module itrd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  itrd_pkg::status_t status,
  output itrd_pkg::cmd_t    cmd
);

  itrd_pkg::state_t                     state;
  itrd_pkg::state_t                     state_next;
  logic [itrd_pkg::CHUNK_CNT_W-1:0]     chunk;
  logic [itrd_pkg::CHUNK_CNT_W-1:0]     chunk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itrd_pkg::ST_IDLE;
      chunk <= '0;
    end else begin
      state <= state_next;
      chunk <= chunk_next;
    end
  end

  always_comb begin
    state_next = state;
    chunk_next = chunk;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      itrd_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = itrd_pkg::ST_START;
        end
      end
      itrd_pkg::ST_START: begin
        chunk_next = '0;
        if (status.mag_zero || !status.base_ok) begin
          state_next = itrd_pkg::ST_ZERO;
        end else begin
          state_next = itrd_pkg::ST_DIV;
        end
      end
      itrd_pkg::ST_ZERO: begin
        cmd.put_zero = 1'b1;
        state_next   = itrd_pkg::ST_PREP;
      end
      itrd_pkg::ST_DIV: begin
        cmd.div    = 1'b1;
        chunk_next = chunk + itrd_pkg::CHUNK_CNT_W'(1);
        if (chunk == itrd_pkg::CHUNK_CNT_W'(itrd_pkg::CHUNKS - 1)) begin
          state_next = itrd_pkg::ST_FIN;
        end
      end
      itrd_pkg::ST_FIN: begin
        cmd.fin    = 1'b1;
        state_next = itrd_pkg::ST_CHECK;
      end
      itrd_pkg::ST_CHECK: begin
        chunk_next = '0;
        priority if (!status.mag_zero && !status.full) begin
          state_next = itrd_pkg::ST_DIV;
        end else if (status.sign_needed && !status.full) begin
          state_next = itrd_pkg::ST_SIGN;
        end else begin
          state_next = itrd_pkg::ST_PREP;
        end
      end
      itrd_pkg::ST_SIGN: begin
        cmd.put_sign = 1'b1;
        state_next   = itrd_pkg::ST_PREP;
      end
      itrd_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        state_next = itrd_pkg::ST_READ;
      end
      itrd_pkg::ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = itrd_pkg::ST_SHOW;
      end
      itrd_pkg::ST_SHOW: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (status.idx_zero) begin
            state_next = itrd_pkg::ST_IDLE;
          end else begin
            cmd.next   = 1'b1;
            state_next = itrd_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_next = itrd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/itrd_dp.sv @@
module itrd_dp #(
  parameter int MAX_CHARS = itrd_pkg::MAX_CHARS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [itrd_pkg::RADIX_W-1:0]    cfg_wdata,
  input  logic [itrd_pkg::VALUE_W-1:0]    value,
  input  itrd_pkg::cmd_t                  cmd,
  output itrd_pkg::status_t               status,
  output logic [itrd_pkg::CHAR_W-1:0]     char_code
);

  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int CW = $clog2(MAX_CHARS + 1);

  logic [itrd_pkg::RADIX_W-1:0] radix;
  logic [itrd_pkg::VALUE_W-1:0] mag;
  logic [itrd_pkg::DIGIT_W-1:0] rem;
  logic                         qsign;
  logic                         vneg;
  logic [CW-1:0]                count;
  logic [AW-1:0]                rd_idx;
  logic [itrd_pkg::CHAR_W-1:0]  mem [MAX_CHARS];

  logic [itrd_pkg::RADIX_W-1:0] rabs;
  logic [itrd_pkg::BASE_W-1:0]  base;
  logic                         neg_base;
  logic [itrd_pkg::DIGIT_W-1:0] rem_next;
  logic [itrd_pkg::CHUNK_BITS-1:0] qbits;
  logic                         corr;
  logic [itrd_pkg::DIGIT_W-1:0] dval;
  logic [itrd_pkg::BASE_W-1:0]  dsub;
  logic [itrd_pkg::CHAR_W-1:0]  wr_char;
  logic                         wr_en;
  logic [CW-1:0]                cnt_m1;

  assign neg_base = radix[itrd_pkg::RADIX_W-1];
  assign rabs     = neg_base ? (itrd_pkg::RADIX_W'(0) - radix) : radix;
  assign base     = rabs[itrd_pkg::BASE_W-1:0];

  always_comb begin
    logic [itrd_pkg::BASE_W-1:0] t;
    logic [itrd_pkg::DIGIT_W-1:0] r;
    r     = rem;
    qbits = '0;
    for (int i = itrd_pkg::CHUNK_BITS - 1; i >= 0; i--) begin
      t = {r, mag[itrd_pkg::VALUE_W - itrd_pkg::CHUNK_BITS + i]};
      if (t >= base) begin
        t        = t - base;
        qbits[i] = 1'b1;
      end
      r = t[itrd_pkg::DIGIT_W-1:0];
    end
    rem_next = r;
  end

  assign corr = neg_base && qsign && (rem != '0);
  assign dsub = base - {1'b0, rem};
  assign dval = corr ? dsub[itrd_pkg::DIGIT_W-1:0] : rem;

  always_comb begin
    wr_en   = cmd.fin || cmd.put_zero || cmd.put_sign;
    wr_char = itrd_pkg::digit_char(dval);
    if (cmd.put_zero) begin
      wr_char = itrd_pkg::CHAR_ZERO;
    end else if (cmd.put_sign) begin
      wr_char = itrd_pkg::CHAR_MINUS;
    end
  end

  assign cnt_m1 = count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itrd_pkg::RADIX_RESET;
      count <= '0;
    end else begin
      if (cfg_we) begin
        radix <= cfg_wdata;
      end
      if (cmd.load) begin
        count <= '0;
      end else if (wr_en) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vneg  <= value[itrd_pkg::VALUE_W-1];
      qsign <= value[itrd_pkg::VALUE_W-1];
      mag   <= value[itrd_pkg::VALUE_W-1] ? (itrd_pkg::VALUE_W'(0) - value) : value;
      rem   <= '0;
    end else if (cmd.div) begin
      mag <= {mag[itrd_pkg::VALUE_W-itrd_pkg::CHUNK_BITS-1:0], qbits};
      rem <= rem_next;
    end else if (cmd.fin) begin
      mag   <= mag + itrd_pkg::VALUE_W'(corr);
      qsign <= neg_base ? !qsign : qsign;
      rem   <= '0;
    end
    if (cmd.prep) begin
      rd_idx <= cnt_m1[AW-1:0];
    end else if (cmd.next) begin
      rd_idx <= rd_idx - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= wr_char;
    end
    if (cmd.rd) begin
      char_code <= mem[rd_idx];
    end
  end

  always_comb begin
    status.mag_zero    = (mag == '0);
    status.base_ok     = (rabs >= itrd_pkg::BASE_MIN) && (rabs <= itrd_pkg::BASE_MAX);
    status.full        = (count == CW'(MAX_CHARS));
    status.sign_needed = vneg && !neg_base;
    status.idx_zero    = (rd_idx == '0);
  end

endmodule

@@ tb/sv/tb_integer_to_radix_digits_core.sv @@
module tb_integer_to_radix_digits_core;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [itrd_pkg::CHAR_W-1:0] code;
    logic                        last;
  } char_item_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [6:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  char_item_t                           expected_chars[$];
  logic signed [itrd_pkg::RADIX_W-1:0]  radix_model;
  int                                   mismatches;
  int                                   cycle_count;
  int                                   hold_cycles;
  bit                                   quiet_sender;
  bit                                   quiet_receiver;

  integer_to_radix_digits_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic logic [itrd_pkg::CHAR_W-1:0] digit_to_ascii(input longint d);
    if (d <= 9) begin
      return itrd_pkg::CHAR_ZERO + itrd_pkg::CHAR_W'(d);
    end
    return itrd_pkg::CHAR_A + itrd_pkg::CHAR_W'(d - 10);
  endfunction

  // Builds the string least significant character first, then queues it in
  // transfer order with the last flag on the final character.
  task automatic predict_string(input logic signed [31:0] v,
                                input logic signed [itrd_pkg::RADIX_W-1:0] r);
    logic [itrd_pkg::CHAR_W-1:0] chars[$];
    longint                      q;
    longint                      b;
    longint                      x;
    char_item_t                  item;
    b = r;
    if (v == 0 || !((b >= 2 && b <= 32) || (b <= -2 && b >= -32))) begin
      chars.push_back(itrd_pkg::CHAR_ZERO);
    end else if (b > 0) begin
      q = (v < 0) ? -longint'(v) : longint'(v);
      while (q != 0 && chars.size() < itrd_pkg::MAX_CHARS_DEFAULT) begin
        chars.push_back(digit_to_ascii(q % b));
        q = q / b;
      end
      if (v < 0 && chars.size() < itrd_pkg::MAX_CHARS_DEFAULT) begin
        chars.push_back(itrd_pkg::CHAR_MINUS);
      end
    end else begin
      q = v;
      while (q != 0 && chars.size() < itrd_pkg::MAX_CHARS_DEFAULT) begin
        x = q % b;
        q = q / b;
        if (x < 0) begin
          x = x - b;
          q = q + 1;
        end
        chars.push_back(digit_to_ascii(x));
      end
    end
    for (int k = chars.size() - 1; k >= 0; k--) begin
      item.code = chars[k];
      item.last = (k == 0);
      expected_chars.push_back(item);
    end
  endtask

  always @(posedge clk) begin : check_output
    char_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected transfer: char %h last %b", m_tdata, m_tlast);
        end
      end else begin
        want = expected_chars.pop_front();
        if (m_tdata !== {1'b0, want.code} || m_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected char %h last %b, got char %h last %b",
                     {1'b0, want.code}, want.last, m_tdata, m_tlast);
          end
        end
      end
    end
  end

  initial begin : drive_ready
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end
      stall = quiet_receiver ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid && hold_cycles == 0);
    end
  end

  task automatic send_value(input logic [31:0] v);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    do @(posedge clk); while (!s_tready);
    predict_string(v, radix_model);
  endtask

  task automatic wait_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_radix(input logic signed [itrd_pkg::RADIX_W-1:0] r);
    wait_until_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_we    <= 1'b0;
    radix_model = r;
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 4))
      0: return 32'($urandom_range(0, 200)) - 32'd100;
      1: return 32'h8000_0000 + 32'($urandom_range(0, 3));
      2: return 32'h7fff_ffff - 32'($urandom_range(0, 3));
      3: return {{16{1'b0}}, 16'($urandom)} - 32'h0000_8000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_default_radix();
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
  endtask

  task automatic test_positive_bases();
    write_radix(7'sd2);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'hffff_ffff);
    write_radix(7'sd32);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    write_radix(7'sd16);
    send_value(32'hdead_beef);
  endtask

  task automatic test_negative_bases();
    write_radix(-7'sd2);
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    send_value(32'hffff_ffff);
    write_radix(-7'sd32);
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    write_radix(-7'sd10);
    send_value(32'hffff_fff1);
  endtask

  task automatic test_unusable_bases();
    write_radix(7'sd0);
    send_value(32'd1234);
    write_radix(7'sd1);
    send_value(32'hffff_ffff);
    write_radix(-7'sd1);
    send_value(32'd77);
    write_radix(7'sd33);
    send_value(32'h8000_0000);
    write_radix(-7'sd33);
    send_value(32'h7fff_ffff);
    write_radix(7'sd63);
    send_value(32'd5);
    write_radix(-7'sd64);
    send_value(32'hffff_fffb);
  endtask

  // The receiver holds off long enough for the block to fill and stall its
  // input while the sender keeps offering random values in base -2.
  task automatic test_output_stall();
    write_radix(-7'sd2);
    quiet_sender = 1'b1;
    hold_cycles  = 700;
    repeat (6) send_value(random_value());
    quiet_sender = 1'b0;
    wait_until_drained();
  endtask

  task automatic test_random_values();
    logic signed [itrd_pkg::RADIX_W-1:0] plan[8];
    plan = '{7'sd2, 7'sd32, -7'sd2, -7'sd32, 7'sd0, 7'sd0, 7'sd10, 7'sd0};
    for (int phase = 0; phase < 8; phase++) begin
      if (plan[phase] == 0) begin
        plan[phase] = itrd_pkg::RADIX_W'($urandom_range(0, 64)) - 7'sd32;
      end
      write_radix(plan[phase]);
      quiet_sender   = (phase == 2 || phase == 5);
      quiet_receiver = (phase == 3 || phase == 6);
      repeat (14) send_value(random_value());
      // The sender pauses here until every queued character has come out.
      wait_until_drained();
      repeat (15) send_value(random_value());
    end
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
  endtask

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    radix_model    = itrd_pkg::RADIX_RESET;
    mismatches     = 0;
    cycle_count    = 0;
    hold_cycles    = 0;
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_radix();
    test_positive_bases();
    test_negative_bases();
    test_unusable_bases();
    test_output_stall();
    test_random_values();

    wait_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
